FILE: rtl/core/ilir_pkg.sv
// Shared types and constants for the indexed list insert/remove unit.
// No dependencies; imported by ilir_cell and indexed_list_insert_remove_unit.
package ilir_pkg;

    // Fixed word field widths
    localparam int OP_W     = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Compare width: holds any position and any cell index up to 511
    localparam int CMP_W    = 9;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    // Status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic             ins;   // insert accepted: open a slot at pos
        logic             rem;   // remove accepted: close the slot at pos
        logic [POS_W-1:0] pos;
    } cmd_t;

endpackage

FILE: rtl/core/ilir_cell.sv
// One list slot: holds an entry and shifts it left or right on command.
// Depends on ilir_pkg (cmd_t, CMP_W).
module ilir_cell #(
    parameter int ITEM_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  ilir_pkg::cmd_t        cmd,
    input  logic [ITEM_WIDTH-1:0] left_value,
    input  logic [ITEM_WIDTH-1:0] right_value,
    input  logic [ITEM_WIDTH-1:0] new_value,
    output logic [ITEM_WIDTH-1:0] value
);
    import ilir_pkg::*;

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [ITEM_WIDTH-1:0] value_reg;
    logic [ITEM_WIDTH-1:0] value_next;
    logic [CMP_W-1:0]      pos_c;

    assign pos_c = CMP_W'(cmd.pos);

    // Slot update: load new word, take from lower neighbor, take from upper neighbor
    always_comb
    begin
        priority if (cmd.ins && (MY_IDX == pos_c))
        begin
            value_next = new_value;
        end
        else if (cmd.ins && (MY_IDX > pos_c))
        begin
            value_next = left_value;
        end
        else if (cmd.rem && (MY_IDX >= pos_c))
        begin
            value_next = right_value;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: rtl/core/indexed_list_insert_remove_unit.sv
// Indexed list insert/remove unit: top level, a row of ilir_cell slots plus control.
// The result word is registered when the input word is accepted.
// Throughput: 1 word per cycle while not stalled; every insert/remove shifts all cells from the position up together.
// Input stalls only while a finished result waits at the output register.
// Reset clears the entry count and output valid; slot contents are undefined until written.
// Depends on ilir_pkg and ilir_cell.
module indexed_list_insert_remove_unit #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ilir_pkg::OP_W-1:0]      op,
    input  logic [ilir_pkg::POS_W-1:0]     position,
    input  logic [ilir_pkg::VALUE_W-1:0]   new_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ilir_pkg::VALUE_W-1:0]   out_value,
    output logic [ilir_pkg::STATUS_W-1:0]  status,
    output logic [ilir_pkg::COUNT_W-1:0]   count
);
    import ilir_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic                  in_accept;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CMP_W-1:0]      pos_c;
    logic [CMP_W-1:0]      cnt_c;
    status_t               status_c;
    logic                  take_value;
    logic                  ins_ok;
    logic                  rem_ok;
    cmd_t                  cmd;
    logic [ITEM_WIDTH-1:0] item_in;
    logic [ITEM_WIDTH-1:0] cell_val [DEPTH];
    logic [ITEM_WIDTH-1:0] sel_val;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_W-1:0]    out_value_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [COUNT_W-1:0]    count_out_reg;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign pos_c     = CMP_W'(position);
    assign cnt_c     = CMP_W'(count_reg);
    assign item_in   = ITEM_WIDTH'(new_value);

    // Decode: status and whether the row shifts
    always_comb
    begin
        status_c   = ST_DONE;
        take_value = 1'b0;
        ins_ok     = 1'b0;
        rem_ok     = 1'b0;
        unique case (op)
            OP_INSERT:
            begin
                if (count_reg == FULL_CNT)
                begin
                    status_c = ST_FULL;
                end
                else if (pos_c > cnt_c)
                begin
                    status_c = ST_RANGE;
                end
                else
                begin
                    ins_ok = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos_c >= cnt_c)
                begin
                    status_c = ST_RANGE;
                end
                else
                begin
                    rem_ok     = 1'b1;
                    take_value = 1'b1;
                end
            end
            OP_READ:
            begin
                if (pos_c >= cnt_c)
                begin
                    status_c = ST_RANGE;
                end
                else
                begin
                    take_value = 1'b1;
                end
            end
            default:
            begin
                status_c = ST_RANGE;
            end
        endcase
    end

    // Command to the cell row, only for accepted words
    assign cmd.ins = in_accept && ins_ok;
    assign cmd.rem = in_accept && rem_ok;
    assign cmd.pos = position;

    // Entry count update
    always_comb
    begin
        priority if (cmd.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Row of cells linked to neighbors; the first cell sees zero on the left, the last sees itself on the right
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ITEM_WIDTH-1:0] left_v;
        logic [ITEM_WIDTH-1:0] right_v;

        if (i == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_mid_l
            assign left_v = cell_val[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_v = cell_val[i];
        end
        else
        begin : g_mid_r
            assign right_v = cell_val[i+1];
        end

        ilir_cell #(
            .ITEM_WIDTH (ITEM_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .left_value  (left_v),
            .right_value (right_v),
            .new_value   (item_in),
            .value       (cell_val[i])
        );
    end

    // Pick the addressed slot: AND-OR over the row
    always_comb
    begin
        sel_val = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CMP_W'(i) == pos_c)
            begin
                sel_val = sel_val | cell_val[i];
            end
        end
    end

    // Output valid
    always_comb
    begin
        priority if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_value_reg <= take_value ? VALUE_W'(sel_val) : '0;
            status_reg    <= status_c;
            count_out_reg <= COUNT_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;
    assign count     = count_out_reg;

    // Count never runs past the row length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    // A completed insert grows the list by one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow count");

    // A refused word leaves the list size alone
    a_refuse_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (status_c != ST_DONE)) |=> $stable(count_reg))
        else $error("refused word changed count");

    // Every accepted word shows up as a result next cycle
    a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted word produced no result");

endmodule
